[sv/swr_pkg.sv]
package swr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;

   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_NACK = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;

   typedef struct packed {
      logic               packet_type;
      logic [7:0]         payload_byte;
      logic signed [31:0] received_sum;
      logic               byte_last;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       run_last;
      logic       message_end;
   } rsp_type;

endpackage

[sv/stop_and_wait_packet_receiver_core.sv]
// Channel   Ports                          Direction  Payload
// request   req_valid, req_stall, req_item in         swr_pkg::req_type, one packet byte
// response  rsp_valid, rsp_stall, rsp_item out        swr_pkg::rsp_type, ACK/NACK/data
//
// A byte that is not the last of its packet is taken without a stall.
// After the last byte the request side stalls while the ACK or NACK is loaded and, for a
// verified packet, while each buffered byte is drained (payload RAM read, then output
// register load); a NACK returns straight to fill.
// Reset (synchronous, active high) clears count, sum, overflow flag, state and output valid.
// A stalled response holds the output register; the drain waits on it.
module stop_and_wait_packet_receiver_core #(
   parameter int MAX_PAYLOAD = swr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  swr_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output swr_pkg::rsp_type rsp_item
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      S_FILL,
      S_RESP,
      S_RD,
      S_DATA
   } state_type;

   state_type        state_ff;
   logic [CW-1:0]    fill_ff,  fill_in;
   logic [15:0]      sum_ff,   sum_in;
   logic             ovf_ff,   ovf_in;
   logic             ok_ff;
   logic             ptype_ff;
   logic [CW-1:0]    idx_ff;
   logic             rsp_valid_ff;
   swr_pkg::rsp_type rsp_item_ff;

   logic             req_accept;
   logic             room;
   logic             out_free;
   logic             rsp_load;
   logic             verdict_ok;
   logic             fin;
   logic [7:0]       rd_data;
   logic [CW-1:0]    idx_next;

   assign req_stall  = (state_ff != S_FILL);
   assign req_accept = req_valid && !req_stall;
   assign room       = (fill_ff < MaxCount);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_load   = out_free && (state_ff == S_RESP || state_ff == S_DATA);
   assign idx_next   = idx_ff + CW'(1);
   assign fin        = (idx_next == fill_ff);

   // Running sum of the bytes read as signed values, wrapping at 16 bits.
   assign sum_in  = sum_ff + {{8{req_item.payload_byte[7]}}, req_item.payload_byte};
   assign fill_in = room ? fill_ff + CW'(1) : fill_ff;
   assign ovf_in  = ovf_ff || !room;

   // Verdict on the packet's last byte: sign-extended sum against the header, no overflow, non-empty.
   assign verdict_ok = !ovf_in && (fill_in != '0) &&
                       ({{16{sum_in[15]}}, sum_in} == req_item.received_sum);

   // Payload RAM: written only during fill, read only during drain, so the
   // two ports never touch the same entry in the same cycle.
   swr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_payload (
      .clock   (clock),
      .wr_en   (req_accept && room),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_item.payload_byte),
      .rd_en   (state_ff == S_RD),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         fill_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // show a newly loaded item, else drop the shown one once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_FILL: begin
               if (req_accept) begin
                  if (req_item.byte_last) begin
                     // hold the count for the drain, clear the rest
                     fill_ff  <= fill_in;
                     sum_ff   <= '0;
                     ovf_ff   <= 1'b0;
                     ok_ff    <= verdict_ok;
                     ptype_ff <= req_item.packet_type;
                     state_ff <= S_RESP;
                  end else begin
                     fill_ff <= fill_in;
                     sum_ff  <= sum_in;
                     ovf_ff  <= ovf_in;
                  end
               end
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_item_ff.data_byte   <= 8'd0;
                  rsp_item_ff.message_end <= 1'b0;
                  idx_ff                  <= '0;
                  if (ok_ff) begin
                     rsp_item_ff.kind     <= swr_pkg::KIND_ACK;
                     rsp_item_ff.run_last <= 1'b0;
                     state_ff             <= S_RD;
                  end else begin
                     rsp_item_ff.kind     <= swr_pkg::KIND_NACK;
                     rsp_item_ff.run_last <= 1'b1;
                     fill_ff              <= '0;
                     state_ff             <= S_FILL;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_DATA;
            end
            S_DATA: begin
               // RAM data holds until the next read, so wait on the output here
               if (out_free) begin
                  rsp_item_ff.kind        <= swr_pkg::KIND_DATA;
                  rsp_item_ff.data_byte   <= rd_data;
                  rsp_item_ff.run_last    <= fin;
                  rsp_item_ff.message_end <= fin && ptype_ff;
                  if (fin) begin
                     fill_ff  <= '0;
                     state_ff <= S_FILL;
                  end else begin
                     idx_ff   <= idx_next;
                     state_ff <= S_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_FILL;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Fill count never passes the buffer depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MaxCount)
      else $error("fill count beyond buffer depth");

   // Drain index stays inside the buffered bytes.
   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD || state_ff == S_DATA) |-> (idx_ff < fill_ff))
      else $error("drain index outside buffered bytes");

   // Message end only on the final data byte of a run.
   a_mend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.message_end) |->
         (rsp_item.kind == swr_pkg::KIND_DATA && rsp_item.run_last))
      else $error("message end off a final data byte");

   // A NACK always closes its run.
   a_nack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.kind == swr_pkg::KIND_NACK) |-> rsp_item.run_last)
      else $error("NACK not marked as run end");

endmodule

[sv/swr_ram.sv]
module swr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
